// ----- design/ipsenc_pkg.sv -----
// ============================================================================
// ipsenc_pkg
// Shared types, constants and byte tables for the IPS patch record encoder.
// ============================================================================
`default_nettype none

package ipsenc_pkg;

    // Run buffer depth and derived widths
    localparam int MAX_RUN   = 32;
    localparam int RUN_LEN_W = $clog2(MAX_RUN + 1);
    localparam int RUN_IDX_W = $clog2(MAX_RUN);
    localparam int ADDR_W    = 40;
    localparam int START_W   = 32;
    localparam int CNT_W     = 3;

    // Last byte positions inside each fixed-size field
    localparam logic [CNT_W-1:0] HDR_LAST        = 3'd4;
    localparam logic [CNT_W-1:0] ADDR_LAST_WIDE  = 3'd3;
    localparam logic [CNT_W-1:0] ADDR_LAST_NARR  = 3'd2;
    localparam logic [CNT_W-1:0] LEN_LAST        = 3'd1;
    localparam logic [CNT_W-1:0] TRL_LAST_WIDE   = 3'd3;
    localparam logic [CNT_W-1:0] TRL_LAST_NARR   = 3'd2;

    // Action codes
    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HEADER,
        S_ADDR,
        S_LEN,
        S_DATA,
        S_TRAILER,
        S_ERROR,
        S_COMMIT
    } t_state;

    // "PATCH" or "IPS32"
    function automatic logic [7:0] header_byte(input logic wide, input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (wide) begin
            case (idx)
                3'd0:    b = 8'h49;
                3'd1:    b = 8'h50;
                3'd2:    b = 8'h53;
                3'd3:    b = 8'h33;
                3'd4:    b = 8'h32;
                default: b = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0:    b = 8'h50;
                3'd1:    b = 8'h41;
                3'd2:    b = 8'h54;
                3'd3:    b = 8'h43;
                3'd4:    b = 8'h48;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // "EOF" or "EEOF"
    function automatic logic [7:0] trailer_byte(input logic wide, input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (wide) begin
            case (idx)
                3'd0:    b = 8'h45;
                3'd1:    b = 8'h45;
                3'd2:    b = 8'h4F;
                3'd3:    b = 8'h46;
                default: b = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0:    b = 8'h45;
                3'd1:    b = 8'h4F;
                3'd2:    b = 8'h46;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // Big-endian record address, 4 bytes wide or 3 bytes narrow
    function automatic logic [7:0] addr_byte(input logic wide,
                                             input logic [START_W-1:0] start,
                                             input logic [CNT_W-1:0] idx);
        logic [START_W-1:0] s;
        logic [7:0]         b;
        s = wide ? start : {start[23:0], 8'h00};
        case (idx)
            3'd0:    b = s[31:24];
            3'd1:    b = s[23:16];
            3'd2:    b = s[15:8];
            3'd3:    b = s[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/ips_patch_record_encoder_core.sv -----
// A byte that extends the pending run is written to the run buffer with no output.
// A byte that starts a run emits header (5, once per patch) plus the previous
// record (5 or 6 + run length bytes), one byte per unstalled cycle, then commit.
// Finish emits header/record as above plus 3 or 4 trailer bytes, or one error byte.
// The single byte sequencer holds on output stalls; input stalls until it is idle.
// Reset (synchronous, active low) clears mode, run state and error; buffer is not cleared.
// ============================================================================
// ips_patch_record_encoder_core
// Groups ascending patched bytes into runs and emits an IPS/IPS32 byte stream.
// ============================================================================
`default_nettype none

module ips_patch_record_encoder_core
    import ipsenc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,

    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire logic              i_action,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [7:0]        i_value,

    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      logic [7:0]        o_out_byte,
    output      logic              o_end_of_patch,
    output      logic              o_error
);

    // Control and patch state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [RUN_IDX_W-1:0]   r_idx, n_idx;
    logic                   r_wide;
    logic                   r_header_sent, n_header_sent;
    logic [START_W-1:0]     r_run_start, n_run_start;
    logic [ADDR_W-1:0]      r_last_addr, n_last_addr;
    logic [RUN_LEN_W-1:0]   r_run_len, n_run_len;
    logic                   r_error_seen, n_error_seen;

    // Accepted transaction
    logic                   r_act;
    logic [ADDR_W-1:0]      r_addr;
    logic [7:0]             r_val;

    // Run buffer
    logic [7:0]             r_mem [MAX_RUN];
    logic [7:0]             r_rd_data;
    logic                   mem_we;
    logic [RUN_IDX_W-1:0]   mem_waddr;
    logic [7:0]             mem_wdata;

    // Output register
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_end;
    logic                   r_out_err;

    // Sequencer byte source
    logic                   seq_emit;
    logic [7:0]             seq_byte;
    logic                   seq_end;
    logic                   seq_err;

    logic                   accept;
    logic                   out_free;
    logic                   step;
    logic                   contig;
    logic                   addr_over;
    logic                   start_over;
    logic                   run_full;
    logic                   data_last;
    logic [15:0]            len16;
    logic [CNT_W-1:0]       addr_last;
    logic [CNT_W-1:0]       trl_last;
    t_state                 first_phase;
    t_state                 after_flush;

    // Handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = !seq_emit || out_free;

    // Decisions taken at transaction acceptance
    assign contig      = (r_run_len != '0) && (i_address == r_last_addr + ADDR_W'(1));
    assign addr_over   = r_wide ? (|i_address[39:32]) : (|i_address[39:24]);
    assign start_over  = (r_run_len != '0) && !r_wide && (|r_run_start[31:24]);
    assign run_full    = (r_run_len >= RUN_LEN_W'(MAX_RUN));
    assign first_phase = !r_header_sent      ? S_HEADER :
                         (r_run_len != '0)   ? S_ADDR   :
                         (i_action == ACT_FINISH) ? S_TRAILER : S_COMMIT;
    assign after_flush = (r_act == ACT_FINISH) ? S_TRAILER : S_COMMIT;

    assign len16       = 16'(r_run_len);
    assign addr_last   = r_wide ? ADDR_LAST_WIDE : ADDR_LAST_NARR;
    assign trl_last    = r_wide ? TRL_LAST_WIDE : TRL_LAST_NARR;
    assign data_last   = (RUN_LEN_W'(r_idx) == r_run_len - RUN_LEN_W'(1));

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    if (i_action == ACT_FINISH) begin
                        n_state = (r_error_seen || start_over) ? S_ERROR : first_phase;
                    end else if (!r_error_seen && !contig && !addr_over && !start_over) begin
                        n_state = first_phase;
                    end
                end
            end
            S_HEADER: begin
                if (step) begin
                    if (r_cnt == HDR_LAST) begin
                        n_cnt   = '0;
                        n_state = (r_run_len != '0) ? S_ADDR : after_flush;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_ADDR: begin
                if (step) begin
                    if (r_cnt == addr_last) begin
                        n_cnt   = '0;
                        n_state = S_LEN;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_LEN: begin
                if (step) begin
                    if (r_cnt == LEN_LAST) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = S_DATA;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_DATA: begin
                if (step) begin
                    if (data_last) begin
                        n_state = after_flush;
                    end else begin
                        n_idx = r_idx + RUN_IDX_W'(1);
                    end
                end
            end
            S_TRAILER: begin
                if (step) begin
                    if (r_cnt == trl_last) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_ERROR: begin
                if (step) begin
                    n_state = S_IDLE;
                end
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Byte produced by the sequencer
    always_comb begin
        seq_emit = 1'b0;
        seq_byte = 8'h00;
        seq_end  = 1'b0;
        seq_err  = 1'b0;
        case (r_state)
            S_HEADER: begin
                seq_emit = 1'b1;
                seq_byte = header_byte(r_wide, r_cnt);
            end
            S_ADDR: begin
                seq_emit = 1'b1;
                seq_byte = addr_byte(r_wide, r_run_start, r_cnt);
            end
            S_LEN: begin
                seq_emit = 1'b1;
                seq_byte = (r_cnt == '0) ? len16[15:8] : len16[7:0];
            end
            S_DATA: begin
                seq_emit = 1'b1;
                seq_byte = r_rd_data;
            end
            S_TRAILER: begin
                seq_emit = 1'b1;
                seq_byte = trailer_byte(r_wide, r_cnt);
                seq_end  = (r_cnt == trl_last);
            end
            S_ERROR: begin
                seq_emit = 1'b1;
                seq_end  = 1'b1;
                seq_err  = 1'b1;
            end
            default: begin
                seq_emit = 1'b0;
            end
        endcase
    end

    // Patch state updates and run buffer writes
    always_comb begin
        n_header_sent = r_header_sent;
        n_run_start   = r_run_start;
        n_last_addr   = r_last_addr;
        n_run_len     = r_run_len;
        n_error_seen  = r_error_seen;
        mem_we        = 1'b0;
        mem_waddr     = r_run_len[RUN_IDX_W-1:0];
        mem_wdata     = i_value;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_BYTE) && !r_error_seen) begin
                    if (contig) begin
                        if (run_full) begin
                            n_error_seen = 1'b1;
                        end else begin
                            mem_we      = 1'b1;
                            n_run_len   = r_run_len + RUN_LEN_W'(1);
                            n_last_addr = i_address;
                        end
                    end else if (addr_over || start_over) begin
                        n_error_seen = 1'b1;
                    end else begin
                        n_header_sent = 1'b1;
                    end
                end else if (accept && (i_action == ACT_FINISH)) begin
                    n_header_sent = 1'b1;
                end
            end
            S_COMMIT: begin
                // New run starts once the previous one has been sent
                mem_we      = 1'b1;
                mem_waddr   = '0;
                mem_wdata   = r_val;
                n_run_start = r_addr[START_W-1:0];
                n_last_addr = r_addr;
                n_run_len   = RUN_LEN_W'(1);
            end
            S_TRAILER, S_ERROR: begin
                if (step && ((r_state == S_ERROR) || (r_cnt == trl_last))) begin
                    n_header_sent = 1'b0;
                    n_run_start   = '0;
                    n_last_addr   = '0;
                    n_run_len     = '0;
                    n_error_seen  = 1'b0;
                end
            end
            default: begin
                n_run_len = r_run_len;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_idx         <= '0;
            r_wide        <= 1'b0;
            r_header_sent <= 1'b0;
            r_run_start   <= '0;
            r_last_addr   <= '0;
            r_run_len     <= '0;
            r_error_seen  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_idx         <= n_idx;
            r_header_sent <= n_header_sent;
            r_run_start   <= n_run_start;
            r_last_addr   <= n_last_addr;
            r_run_len     <= n_run_len;
            r_error_seen  <= n_error_seen;
            if (i_cfg_we) begin
                r_wide <= i_cfg_wdata;
            end
            if (out_free) begin
                r_out_valid <= seq_emit;
            end
        end
    end

    // Transaction capture and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_addr <= i_address;
            r_val  <= i_value;
        end
        if (seq_emit && out_free) begin
            r_out_byte <= seq_byte;
            r_out_end  <= seq_end;
            r_out_err  <= seq_err;
        end
    end

    // Run buffer: one write port, registered read at the next data index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[n_idx];
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_patch = r_out_end;
    assign o_error        = r_out_err;

endmodule

`default_nettype wire
